// ===== design/sapp_pkg.sv =====
`default_nettype none
package sapp_pkg;

  // Datagram framing
  localparam int MAX_PACKET_BYTES = 2048;
  localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 2);
  localparam int HDR_BYTES        = 8;
  localparam int TAG_BYTES        = 16;
  localparam int TAG_W            = 4;
  localparam int TAG_END          = HDR_BYTES + TAG_BYTES;
  localparam int ID_END           = 4;

  // SDP byte count, saturating
  localparam int               LEN_W   = 11;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  // Header flag fields
  localparam logic [2:0] VERSION_MASK = 3'h7;
  localparam logic [2:0] SAP_VERSION  = 3'h1;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_BAD_VER  = 3'd2,
    ST_NOT_IPV4 = 3'd3,
    ST_CRYPT    = 3'd4,
    ST_AUTH     = 3'd5,
    ST_LONG     = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    B_HEAD,
    B_RPL_RD,
    B_RPL_OUT,
    B_SUM
  } back_state_e;

  typedef struct packed {
    status_e          status;
    logic             kind;
    logic [15:0]      id;
    logic [31:0]      origin;
    logic [LEN_W-1:0] sdp_len;
    logic             mime;
  } summary_t;

  // One command per beat that needs work in the back
  typedef struct packed {
    logic             store;
    logic             emit;
    logic             replay;
    logic             summary;
    logic [TAG_W-1:0] tag_idx;
    logic [7:0]       data;
    summary_t         sum;
  } cmd_t;

  // "application/sdp" plus a NUL byte
  function automatic logic [7:0] tag_char(input logic [TAG_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h61;
      4'd1:    c = 8'h70;
      4'd2:    c = 8'h70;
      4'd3:    c = 8'h6C;
      4'd4:    c = 8'h69;
      4'd5:    c = 8'h63;
      4'd6:    c = 8'h61;
      4'd7:    c = 8'h74;
      4'd8:    c = 8'h69;
      4'd9:    c = 8'h6F;
      4'd10:   c = 8'h6E;
      4'd11:   c = 8'h2F;
      4'd12:   c = 8'h73;
      4'd13:   c = 8'h64;
      4'd14:   c = 8'h70;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== design/sap_announcement_parser.sv =====
// SAP announcement header parser.
// Input channel: one datagram byte per beat (data_byte_i, end_of_packet_i
// marks the final byte), handshake in_valid_i / in_stall_o.
// Output channel: result beats on out_valid_o / out_stall_i. Payload beats
// (item_type_o = 0) carry SDP bytes; the summary beat (item_type_o = 1) ends
// each datagram with status, kind, id, origin, SDP length and tag flag.
// run_last_o marks the final result caused by one input byte.
// A front stage parses and classifies each byte and posts commands into a
// 4-entry queue; a back stage executes them into the output register.
// Each input byte passes through a queue slot and then the output register
// before its first result beat is presented. Throughput: 1 input byte per
// cycle while the queue has room. The back runs a payload byte, a tag byte
// or a lone summary straight from the queue head, and a last payload byte
// with its summary as a payload beat then a summary beat; a tag replay
// starts, then does a registered tag memory read and an output for each of
// 16 bytes.
// Header bytes post nothing, so the queue drains while they arrive.
// Reset clears all parse state and empties queue and output register.
// When the receiver stalls, the output beat holds, the queue fills and then
// in_stall_o rises; no byte or result is lost.
`default_nettype none
module sap_announcement_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_packet_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             item_type_o,
  output logic [7:0]       payload_byte_o,
  output logic             run_last_o,
  output logic [2:0]       status_o,
  output logic             msg_kind_o,
  output logic [15:0]      msg_id_o,
  output logic [31:0]      origin_ipv4_o,
  output logic [10:0]      sdp_length_o,
  output logic             mime_present_o
);

  logic           q_full, q_push, q_pop, q_valid;
  sapp_pkg::cmd_t push_cmd, head_cmd;

  sapp_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .end_of_packet_i (end_of_packet_i),
    .q_full_i        (q_full),
    .push_o          (q_push),
    .cmd_o           (push_cmd)
  );

  sapp_cmd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (head_cmd)
  );

  sapp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .cmd_i          (head_cmd),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .item_type_o    (item_type_o),
    .payload_byte_o (payload_byte_o),
    .run_last_o     (run_last_o),
    .status_o       (status_o),
    .msg_kind_o     (msg_kind_o),
    .msg_id_o       (msg_id_o),
    .origin_ipv4_o  (origin_ipv4_o),
    .sdp_length_o   (sdp_length_o),
    .mime_present_o (mime_present_o)
  );

endmodule
`default_nettype wire

// ===== design/sapp_front.sv =====
`default_nettype none
module sapp_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          end_of_packet_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output sapp_pkg::cmd_t     cmd_o
);

  logic [sapp_pkg::POS_W-1:0] pos_q, pos_d;
  logic [2:0]                 herr_q, herr_d;
  logic                       kind_q, kind_d;
  logic [15:0]                id_q, id_d;
  logic [31:0]                origin_q, origin_d;
  logic                       match_q, match_d;
  logic [sapp_pkg::LEN_W-1:0] cnt_q, cnt_d;

  logic                         accept;
  logic                         in_range;
  logic [sapp_pkg::TAG_W-1:0]   tag_idx;
  logic [sapp_pkg::LEN_W:0]     cnt_sum;
  logic                         full_len;
  sapp_pkg::cmd_t               cmd;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign in_range   = pos_q < sapp_pkg::POS_W'(sapp_pkg::MAX_PACKET_BYTES);
  assign tag_idx    = sapp_pkg::TAG_W'(pos_q[sapp_pkg::TAG_W-1:0]
                                       - sapp_pkg::TAG_W'(sapp_pkg::HDR_BYTES));

  // Classify the beat by position and update per-packet state
  always_comb begin
    pos_d    = pos_q;
    herr_d   = herr_q;
    kind_d   = kind_q;
    id_d     = id_q;
    origin_d = origin_q;
    match_d  = match_q;
    cnt_d    = cnt_q;
    cnt_sum  = '0;
    full_len = 1'b0;
    cmd      = '0;
    cmd.tag_idx = tag_idx;
    cmd.data    = data_byte_i;

    if (in_range) begin
      if (pos_q == '0) begin
        kind_d = data_byte_i[2];
        if ((data_byte_i[7:5] & sapp_pkg::VERSION_MASK) != sapp_pkg::SAP_VERSION) begin
          herr_d = sapp_pkg::ST_BAD_VER;
        end else if (data_byte_i[4]) begin
          herr_d = sapp_pkg::ST_NOT_IPV4;
        end else if (data_byte_i[1:0] != 2'b00) begin
          herr_d = sapp_pkg::ST_CRYPT;
        end
      end else if (pos_q == sapp_pkg::POS_W'(1)) begin
        if (herr_q == sapp_pkg::ST_OK && data_byte_i != 8'h00) begin
          herr_d = sapp_pkg::ST_AUTH;
        end
      end else if (pos_q < sapp_pkg::POS_W'(sapp_pkg::ID_END)) begin
        id_d = {id_q[7:0], data_byte_i};
      end else if (pos_q < sapp_pkg::POS_W'(sapp_pkg::HDR_BYTES)) begin
        origin_d = {origin_q[23:0], data_byte_i};
      end else if (pos_q < sapp_pkg::POS_W'(sapp_pkg::TAG_END)) begin
        cmd.store = 1'b1;
        match_d   = match_q && (data_byte_i == sapp_pkg::tag_char(tag_idx));
        if (tag_idx == sapp_pkg::TAG_W'(sapp_pkg::TAG_BYTES - 1) &&
            herr_q == sapp_pkg::ST_OK && !match_d) begin
          cmd.replay = 1'b1;
          cnt_sum    = {1'b0, cnt_q} + (sapp_pkg::LEN_W + 1)'(sapp_pkg::TAG_BYTES);
          cnt_d      = cnt_sum > {1'b0, sapp_pkg::LEN_MAX} ? sapp_pkg::LEN_MAX
                                                          : cnt_sum[sapp_pkg::LEN_W-1:0];
        end
      end else if (herr_q == sapp_pkg::ST_OK) begin
        cmd.emit = 1'b1;
        cnt_d    = cnt_q == sapp_pkg::LEN_MAX ? cnt_q : cnt_q + 1'b1;
      end
    end

    if (pos_q <= sapp_pkg::POS_W'(sapp_pkg::MAX_PACKET_BYTES)) begin
      pos_d = pos_q + 1'b1;
    end

    // End of packet: summary from the updated state, then clear
    if (end_of_packet_i) begin
      full_len    = pos_d >= sapp_pkg::POS_W'(sapp_pkg::TAG_END);
      cmd.summary = 1'b1;
      if (!full_len) begin
        cmd.sum.status = sapp_pkg::ST_SHORT;
      end else if (herr_d != sapp_pkg::ST_OK) begin
        cmd.sum.status = sapp_pkg::status_e'(herr_d);
      end else if (pos_d > sapp_pkg::POS_W'(sapp_pkg::MAX_PACKET_BYTES)) begin
        cmd.sum.status = sapp_pkg::ST_LONG;
      end else begin
        cmd.sum.status = sapp_pkg::ST_OK;
      end
      cmd.sum.kind    = kind_d;
      cmd.sum.id      = id_d;
      cmd.sum.origin  = origin_d;
      cmd.sum.sdp_len = (!full_len || herr_d != sapp_pkg::ST_OK) ? '0 : cnt_d;
      cmd.sum.mime    = full_len && herr_d == sapp_pkg::ST_OK && match_d;
      pos_d    = '0;
      herr_d   = sapp_pkg::ST_OK;
      kind_d   = 1'b0;
      id_d     = '0;
      origin_d = '0;
      match_d  = 1'b1;
      cnt_d    = '0;
    end
  end

  assign cmd_o  = cmd;
  assign push_o = accept && (cmd.store || cmd.emit || cmd.summary);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      herr_q   <= sapp_pkg::ST_OK;
      kind_q   <= 1'b0;
      id_q     <= '0;
      origin_q <= '0;
      match_q  <= 1'b1;
      cnt_q    <= '0;
    end else if (accept) begin
      pos_q    <= pos_d;
      herr_q   <= herr_d;
      kind_q   <= kind_d;
      id_q     <= id_d;
      origin_q <= origin_d;
      match_q  <= match_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/sapp_cmd_queue.sv =====
`default_nettype none
module sapp_cmd_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire sapp_pkg::cmd_t push_cmd_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output sapp_pkg::cmd_t      head_o
);

  sapp_pkg::cmd_t              slot_q [sapp_pkg::QUEUE_DEPTH];
  logic [sapp_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [sapp_pkg::QPTR_W:0]   count_q;
  logic                        do_push, do_pop;

  assign full_o  = count_q == (sapp_pkg::QPTR_W + 1)'(sapp_pkg::QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule
`default_nettype wire

// ===== design/sapp_back.sv =====
`default_nettype none
module sapp_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_valid_i,
  input  wire sapp_pkg::cmd_t cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic                item_type_o,
  output logic [7:0]          payload_byte_o,
  output logic                run_last_o,
  output logic [2:0]          status_o,
  output logic                msg_kind_o,
  output logic [15:0]         msg_id_o,
  output logic [31:0]         origin_ipv4_o,
  output logic [sapp_pkg::LEN_W-1:0] sdp_length_o,
  output logic                mime_present_o
);

  sapp_pkg::back_state_e state_q, state_d;

  logic [7:0]                 tag_mem_q [sapp_pkg::TAG_BYTES];
  logic [7:0]                 rdata_q;
  logic [sapp_pkg::TAG_W-1:0] ridx_q;
  logic                       ridx_last;

  logic       out_free;
  logic       mem_we, rd_en, ridx_clr, ridx_inc;
  logic       load_pay, load_sum, pay_last;
  logic [7:0] pay_data;

  // Output register
  logic                       ovalid_q;
  logic                       otype_q;
  logic [7:0]                 obyte_q;
  logic                       olast_q;
  sapp_pkg::summary_t         osum_q;

  assign out_free  = !ovalid_q || !out_stall_i;
  assign ridx_last = ridx_q == sapp_pkg::TAG_W'(sapp_pkg::TAG_BYTES - 1);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sapp_pkg::B_HEAD: begin
        if (q_valid_i) begin
          if (cmd_i.replay) begin
            state_d = sapp_pkg::B_RPL_RD;
          end else if (cmd_i.emit && cmd_i.summary && out_free) begin
            state_d = sapp_pkg::B_SUM;
          end
        end
      end
      sapp_pkg::B_RPL_RD: state_d = sapp_pkg::B_RPL_OUT;
      sapp_pkg::B_RPL_OUT: begin
        if (out_free) begin
          if (!ridx_last) begin
            state_d = sapp_pkg::B_RPL_RD;
          end else if (cmd_i.summary) begin
            state_d = sapp_pkg::B_SUM;
          end else begin
            state_d = sapp_pkg::B_HEAD;
          end
        end
      end
      sapp_pkg::B_SUM: begin
        if (out_free) state_d = sapp_pkg::B_HEAD;
      end
      default: state_d = sapp_pkg::B_HEAD;
    endcase
  end

  // Control outputs
  always_comb begin
    pop_o    = 1'b0;
    mem_we   = 1'b0;
    rd_en    = 1'b0;
    ridx_clr = 1'b0;
    ridx_inc = 1'b0;
    load_pay = 1'b0;
    load_sum = 1'b0;
    pay_last = 1'b0;
    pay_data = cmd_i.data;
    unique case (state_q)
      sapp_pkg::B_HEAD: begin
        if (q_valid_i) begin
          mem_we = cmd_i.store;
          if (cmd_i.replay) begin
            ridx_clr = 1'b1;
          end else if (cmd_i.emit) begin
            if (out_free) begin
              load_pay = 1'b1;
              pay_last = !cmd_i.summary;
              pop_o    = !cmd_i.summary;
            end
          end else if (cmd_i.summary) begin
            if (out_free) begin
              load_sum = 1'b1;
              pop_o    = 1'b1;
            end
          end else begin
            pop_o = 1'b1;
          end
        end
      end
      sapp_pkg::B_RPL_RD: rd_en = 1'b1;
      sapp_pkg::B_RPL_OUT: begin
        pay_data = rdata_q;
        if (out_free) begin
          load_pay = 1'b1;
          ridx_inc = 1'b1;
          pay_last = ridx_last && !cmd_i.summary;
          pop_o    = ridx_last && !cmd_i.summary;
        end
      end
      sapp_pkg::B_SUM: begin
        if (out_free) begin
          load_sum = 1'b1;
          pop_o    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Tag byte store and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) tag_mem_q[cmd_i.tag_idx] <= cmd_i.data;
    if (rd_en)  rdata_q <= tag_mem_q[ridx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sapp_pkg::B_HEAD;
      ridx_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ridx_clr) begin
        ridx_q <= '0;
      end else if (ridx_inc) begin
        ridx_q <= ridx_q + 1'b1;
      end
      if (load_pay || load_sum) begin
        ovalid_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Result beat payload
  always_ff @(posedge clk_i) begin
    if (load_pay) begin
      otype_q <= 1'b0;
      obyte_q <= pay_data;
      olast_q <= pay_last;
      osum_q  <= '0;
    end else if (load_sum) begin
      otype_q <= 1'b1;
      obyte_q <= 8'h00;
      olast_q <= 1'b1;
      osum_q  <= cmd_i.sum;
    end
  end

  assign out_valid_o    = ovalid_q;
  assign item_type_o    = otype_q;
  assign payload_byte_o = obyte_q;
  assign run_last_o     = olast_q;
  assign status_o       = osum_q.status;
  assign msg_kind_o     = osum_q.kind;
  assign msg_id_o       = osum_q.id;
  assign origin_ipv4_o  = osum_q.origin;
  assign sdp_length_o   = osum_q.sdp_len;
  assign mime_present_o = osum_q.mime;

endmodule
`default_nettype wire
